// File: hw/rtl/hns_pkg.sv
// Shared types and constants for the held note stack.
// Holds event codes, channel payload structs and controller/datapath command and status structs.
// No dependencies.
package hns_pkg;

	localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
	localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
	localparam logic [1:0] FUNC_ALL_OFF  = 2'd2;

	localparam int NOTE_W  = 7;
	localparam int HELD_W  = 8;

	typedef struct packed {
		logic [1:0]        func;
		logic [NOTE_W-1:0] note_number;
	} evt_t;

	typedef struct packed {
		logic              any_held;
		logic [NOTE_W-1:0] newest_note;
		logic [HELD_W-1:0] held_count;
	} res_t;

	typedef struct packed {
		logic load_evt;
		logic search_init;
		logic search_step;
		logic copy_init_full;
		logic copy_init_hit;
		logic copy_step;
		logic dec_count;
		logic push;
		logic clear_count;
		logic read_top;
		logic capture_top;
		logic load_res;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       empty;
		logic       full;
		logic       hit;
		logic       miss;
		logic       copy_done;
		logic       res_free;
	} dp_sts_t;

endpackage

// File: hw/rtl/hns_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used for the event input and the result output; no dependencies.
interface hns_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/held_note_stack.sv
// Top level of the held note stack: last-note-priority stack of held note numbers.
// Depends on hns_pkg, hns_stream_if, hns_ctrl and hns_dp.
//
//   channel  dir  payload                                   transfer
//   evt      in   func, note_number                         valid & ready
//   res      out  any_held, newest_note, held_count         valid & ready
//
// One event at a time; the single read port and single write port of the slot RAM set the pace.
// Note-on pushes the note on top; when the stack is full the oldest note is dropped (shift down one slot per cycle).
// Note-off searches down from the top; a hit removes the newest matching note, shifts the slots above it
// down and rereads the top; all-notes-off clears the count; an unknown code changes nothing.
// Reset empties the stack at once; slots are never cleared.
// A result waiting in the output register holds only the final step of the next event.
module held_note_stack #(
	parameter int DEPTH = 128
) (
	input logic          clk,
	input logic          arst_n,
	hns_stream_if.sink   evt,
	hns_stream_if.source res
);
	import hns_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	evt_t    evt_data;
	res_t    res_data;

	assign evt_data = evt.data;
	assign res.data = res_data;

	hns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hns_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_data  (evt_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res.valid),
		.res_data  (res_data),
		.res_ready (res.ready)
	);

	a_busy_after_evt: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready |=> !evt.ready)
		else $error("ready not dropped after event transaction");

	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.search_step, cmd.copy_step, cmd.read_top}))
		else $error("slot RAM read port claimed twice");

	a_res_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |=> res.valid)
		else $error("result load did not raise valid");

	a_held_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (DEPTH < 256) |-> res_data.any_held == (res_data.held_count != 8'd0))
		else $error("any_held disagrees with held_count");

endmodule

// File: hw/rtl/hns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the note slots; no dependencies.
module hns_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/hns_dp.sv
// Datapath of the held note stack: slot RAM, count, scan pointer, top-of-stack and result register.
// Depends on hns_pkg and hns_ram.
module hns_dp #(
	parameter int DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hns_pkg::evt_t     evt_data,
	input  hns_pkg::dp_cmd_t  cmd,
	output hns_pkg::dp_sts_t  sts,
	output logic              res_valid,
	output hns_pkg::res_t     res_data,
	input  logic              res_ready
);
	import hns_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0]        func_q;
	logic [NOTE_W-1:0] note_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic [NOTE_W-1:0] top_q;
	logic              scan_end_q;
	logic              rd_valid_s1;
	logic [AW-1:0]     rd_addr_s1;
	logic              res_valid_q;
	res_t              res_q;

	logic              search_rd;
	logic              copy_rd;
	logic              re;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [NOTE_W-1:0] wdata;
	logic [NOTE_W-1:0] rdata;
	logic              match;
	logic [CW-1:0]     count_m1;
	logic [CW+HELD_W-1:0] count_ext;

	assign count_m1  = count_q - CW'(1);
	assign search_rd = cmd.search_step && !scan_end_q;
	assign copy_rd   = cmd.copy_step && (ptr_q < count_q);
	assign re        = search_rd || copy_rd || cmd.read_top;
	assign raddr     = cmd.read_top ? count_m1[AW-1:0] : ptr_q[AW-1:0];
	assign we        = (cmd.copy_step && rd_valid_s1) || cmd.push;
	assign waddr     = cmd.push ? count_q[AW-1:0] : rd_addr_s1 - AW'(1);
	assign wdata     = cmd.push ? note_q : rdata;
	assign match     = rd_valid_s1 && (rdata == note_q);
	assign count_ext = {{HELD_W{1'b0}}, count_q};

	hns_ram #(
		.WIDTH (NOTE_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_evt) begin
			func_q <= evt_data.func;
			note_q <= evt_data.note_number;
		end
		if (cmd.push) begin
			top_q <= note_q;
		end else if (cmd.capture_top) begin
			top_q <= rdata;
		end
		if (re) begin
			rd_addr_s1 <= raddr;
		end
		if (cmd.load_res) begin
			res_q.any_held    <= (count_q != '0);
			res_q.newest_note <= (count_q != '0) ? top_q : '0;
			res_q.held_count  <= count_ext[HELD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			scan_end_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= re;
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.dec_count) begin
				count_q <= count_m1;
			end else if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.search_init) begin
				ptr_q      <= count_m1;
				scan_end_q <= 1'b0;
			end else if (search_rd) begin
				if (ptr_q == '0) begin
					scan_end_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q - CW'(1);
				end
			end else if (cmd.copy_init_full) begin
				ptr_q <= CW'(1);
			end else if (cmd.copy_init_hit) begin
				ptr_q <= CW'(rd_addr_s1) + CW'(1);
			end else if (copy_rd) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign sts.func      = func_q;
	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.hit       = match;
	assign sts.miss      = rd_valid_s1 && !match && (rd_addr_s1 == '0);
	assign sts.copy_done = (ptr_q >= count_q) && !rd_valid_s1;
	assign sts.res_free  = !res_valid_q || res_ready;

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// File: hw/rtl/hns_ctrl.sv
// Controller state machine of the held note stack: sequences push, search, compaction and result.
// Depends on hns_pkg.
module hns_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_ready,
	input  hns_pkg::dp_sts_t  sts,
	output hns_pkg::dp_cmd_t  cmd
);
	import hns_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECODE  = 3'd1;
	localparam logic [2:0] ST_SEARCH  = 3'd2;
	localparam logic [2:0] ST_COPY    = 3'd3;
	localparam logic [2:0] ST_PUSH    = 3'd4;
	localparam logic [2:0] ST_RDTOP   = 3'd5;
	localparam logic [2:0] ST_TOPWAIT = 3'd6;
	localparam logic [2:0] ST_FINISH  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd       = '0;
		evt_ready = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				evt_ready = 1'b1;
				if (evt_valid) begin
					cmd.load_evt = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (sts.func)
					FUNC_NOTE_ON: begin
						if (sts.full) begin
							cmd.copy_init_full = 1'b1;
							state_d            = ST_COPY;
						end else begin
							state_d = ST_PUSH;
						end
					end
					FUNC_NOTE_OFF: begin
						if (sts.empty) begin
							state_d = ST_FINISH;
						end else begin
							cmd.search_init = 1'b1;
							state_d         = ST_SEARCH;
						end
					end
					FUNC_ALL_OFF: begin
						cmd.clear_count = 1'b1;
						state_d         = ST_FINISH;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_SEARCH: begin
				if (sts.hit) begin
					cmd.copy_init_hit = 1'b1;
					state_d           = ST_COPY;
				end else if (sts.miss) begin
					state_d = ST_FINISH;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			ST_COPY: begin
				if (sts.copy_done) begin
					cmd.dec_count = 1'b1;
					state_d       = (sts.func == FUNC_NOTE_ON) ? ST_PUSH : ST_RDTOP;
				end else begin
					cmd.copy_step = 1'b1;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_RDTOP: begin
				if (sts.empty) begin
					state_d = ST_FINISH;
				end else begin
					cmd.read_top = 1'b1;
					state_d      = ST_TOPWAIT;
				end
			end
			ST_TOPWAIT: begin
				cmd.capture_top = 1'b1;
				state_d         = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.res_free) begin
					cmd.load_res = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: bench/held_note_stack_test.sv
// Self-checking bench for held_note_stack: random and directed note events, scoreboarded results.
// Depends on hns_pkg, hns_stream_if and the held_note_stack RTL.
module held_note_stack_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hns_pkg::*;

	localparam int STACK_DEPTH   = 128;
	localparam int RANDOM_EVENTS = 800;
	localparam int IDLE_LIMIT    = 4000;
	localparam int HOLD_OFF      = 400;
	localparam int TAIL_CYCLES   = 2 * STACK_DEPTH + 40;
	localparam int PRINT_LIMIT   = 50;

	localparam logic [1:0] FUNC_UNDEFINED = 2'd3;

	class note_stack_scoreboard;
		bit [NOTE_W-1:0] held_notes[$];
		res_t            predicted_results[$];
		int              fail_count;

		function void note_event(evt_t e);
			res_t r;
			case (e.func)
				FUNC_NOTE_ON: begin
					if (held_notes.size() >= STACK_DEPTH)
						void'(held_notes.pop_front());
					held_notes.insert(held_notes.size(), e.note_number);
				end
				FUNC_NOTE_OFF: begin
					for (int i = held_notes.size() - 1; i >= 0; i--) begin
						if (held_notes[i] == e.note_number) begin
							held_notes.delete(i);
							break;
						end
					end
				end
				FUNC_ALL_OFF: held_notes.delete();
				default: ;
			endcase
			r.any_held    = held_notes.size() > 0;
			r.newest_note = held_notes.size() > 0 ? held_notes[$] : '0;
			r.held_count  = HELD_W'(held_notes.size());
			predicted_results.insert(predicted_results.size(), r);
		endfunction

		task report_mismatch(string msg);
			fail_count++;
			if (fail_count <= PRINT_LIMIT)
				$display("%0t: mismatch: %s", $realtime, msg);
		endtask

		task check_result(res_t got);
			res_t want;
			if (predicted_results.size() == 0) begin
				report_mismatch($sformatf("result %p with nothing pending", got));
				return;
			end
			want = predicted_results.pop_front();
			if (got.any_held !== want.any_held)
				report_mismatch($sformatf("any_held %b, want %b", got.any_held, want.any_held));
			if (got.newest_note !== want.newest_note)
				report_mismatch($sformatf("newest_note %0d, want %0d",
					got.newest_note, want.newest_note));
			if (got.held_count !== want.held_count)
				report_mismatch($sformatf("held_count %0d, want %0d",
					got.held_count, want.held_count));
		endtask

		function int pending();
			return predicted_results.size();
		endfunction

		function int count();
			return held_notes.size();
		endfunction

		function bit [NOTE_W-1:0] pick_held();
			if (held_notes.size() == 0)
				return NOTE_W'($urandom_range(0, 127));
			return held_notes[$urandom_range(0, held_notes.size() - 1)];
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hns_stream_if #(.payload_t(evt_t)) evt_if ();
	hns_stream_if #(.payload_t(res_t)) res_if ();

	held_note_stack #(.DEPTH(STACK_DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_if),
		.res    (res_if)
	);

	note_stack_scoreboard sb = new();

	bit sender_steady;
	bit receiver_steady;
	bit hold_off_req;
	bit reset_done;
	int events_sent;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		evt_if.valid <= 1'b0;
		evt_if.data <= '0;
		res_if.ready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		reset_done = 1'b1;
	end

	task automatic send_event(input logic [1:0] f, input logic [NOTE_W-1:0] n);
		evt_t e;
		int   gap;
		e.func = f;
		e.note_number = n;
		gap = sender_steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			evt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_if.valid <= 1'b1;
		evt_if.data <= e;
		do @(posedge clk); while (!evt_if.ready);
		sb.note_event(e);
		events_sent++;
	endtask

	task automatic pause_until_drained();
		evt_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic play_chord(input int k);
		int rel;
		for (int i = 0; i < k; i++)
			send_event(FUNC_NOTE_ON, ($urandom_range(0, 5) == 0) ? sb.pick_held()
				: NOTE_W'($urandom_range(0, 127)));
		rel = $urandom_range(0, k);
		for (int i = 0; i < rel; i++)
			send_event(FUNC_NOTE_OFF, ($urandom_range(0, 7) == 0)
				? NOTE_W'($urandom_range(0, 127)) : sb.pick_held());
	endtask

	task automatic fill_stack();
		int target;
		target = STACK_DEPTH + $urandom_range(1, 6);
		while (sb.count() < STACK_DEPTH)
			send_event(FUNC_NOTE_ON, NOTE_W'($urandom_range(0, 127)));
		for (int i = 0; i < target - STACK_DEPTH; i++)
			send_event(FUNC_NOTE_ON, NOTE_W'($urandom_range(0, 127)));
		for (int i = 0; i < 6; i++)
			send_event(FUNC_NOTE_OFF, sb.pick_held());
	endtask

	// result side: random stalls, steady stretches and one long hold-off
	initial begin
		int stall;
		wait (reset_done);
		forever begin
			if (hold_off_req) begin
				stall = HOLD_OFF;
				hold_off_req = 1'b0;
			end else begin
				stall = receiver_steady ? 0 : $urandom_range(0, 19);
			end
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			sb.check_result(res_if.data);
		end
	end

	initial begin
		int idle_cycles;
		wait (reset_done);
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("held_note_stack_test NOT OK");
		$finish;
	end

	initial begin
		int fills;
		wait (reset_done);
		@(posedge clk);

		send_event(FUNC_NOTE_OFF, 7'd0);
		send_event(FUNC_UNDEFINED, 7'd127);
		send_event(FUNC_ALL_OFF, 7'd127);
		send_event(FUNC_NOTE_ON, 7'd0);
		send_event(FUNC_NOTE_ON, 7'd127);
		send_event(FUNC_NOTE_ON, 7'd0);
		send_event(FUNC_NOTE_ON, 7'h55);
		send_event(FUNC_NOTE_ON, 7'h2a);
		send_event(FUNC_NOTE_OFF, 7'd100);
		send_event(FUNC_NOTE_OFF, 7'd0);
		send_event(FUNC_UNDEFINED, 7'h55);
		send_event(FUNC_NOTE_OFF, 7'd127);
		send_event(FUNC_NOTE_OFF, 7'h2a);
		send_event(FUNC_NOTE_OFF, 7'h55);
		send_event(FUNC_NOTE_OFF, 7'd0);
		send_event(FUNC_NOTE_OFF, 7'd0);
		send_event(FUNC_NOTE_ON, 7'd1);
		send_event(FUNC_NOTE_ON, 7'd2);
		send_event(FUNC_ALL_OFF, 7'd127);
		send_event(FUNC_NOTE_ON, 7'd127);
		send_event(FUNC_ALL_OFF, 7'd0);
		pause_until_drained();

		// back up the result side while the event side keeps offering
		sender_steady = 1'b1;
		hold_off_req = 1'b1;
		play_chord(24);
		sender_steady = 1'b0;
		pause_until_drained();

		events_sent = 0;
		fills = 0;
		while (events_sent < RANDOM_EVENTS) begin
			sender_steady = $urandom_range(0, 3) == 0;
			receiver_steady = $urandom_range(0, 3) == 0;
			if (fills < 2 && events_sent >= fills * 400 + 100) begin
				fill_stack();
				fills++;
				continue;
			end
			case ($urandom_range(0, 19)) inside
				[0:3]: begin
					for (int i = $urandom_range(1, 4); i > 0; i--)
						send_event(2'($urandom_range(0, 3)), NOTE_W'($urandom_range(0, 127)));
				end
				4: send_event(FUNC_ALL_OFF, NOTE_W'($urandom_range(0, 127)));
				[5:7]: begin
					for (int i = $urandom_range(1, 6); i > 0; i--)
						send_event(FUNC_NOTE_OFF, ($urandom_range(0, 4) == 0)
							? NOTE_W'($urandom_range(0, 127)) : sb.pick_held());
				end
				default: play_chord($urandom_range(1, 8));
			endcase
			if ($urandom_range(0, 60) == 0)
				pause_until_drained();
		end

		sender_steady = 1'b0;
		receiver_steady = 1'b0;
		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("held_note_stack_test OK");
		else
			$display("held_note_stack_test NOT OK");
		$finish;
	end

endmodule
